/* src/qte_pkg.sv */
// Shared types and constants for the quaternion to Euler angle converter.
`default_nettype none

package qte_pkg;

    // Number of root bits produced by the square root chain, one per cell.
    localparam int ISQRT_STEPS = 31;

    // Vector and angle widths inside the CORDIC cells (angles scaled 2^-30 rad).
    localparam int VEC_W = 37;
    localparam int ANG_W = 34;

    localparam logic signed [ANG_W-1:0] ANG_PI_HALF = 34'sd1686629713;
    localparam logic signed [32:0]      TEST_LIMIT  = 33'sd535822336;
    localparam logic signed [18:0]      PITCH_LIM   = 19'sd12868;
    localparam logic signed [18:0]      YAW_LIM     = 19'sd25736;
    localparam logic signed [18:0]      ROLL_LIM    = 19'sd6434;
    localparam logic signed [18:0]      Q12_HALF_PI = 19'sd6434;

    // One vector travelling through the CORDIC chain.
    typedef struct packed {
        logic signed [VEC_W-1:0] xv;
        logic signed [VEC_W-1:0] yv;
        logic signed [ANG_W-1:0] ang;
        logic                    zero;
    } cord_t;

    // Partial state of the digit-by-digit square root.
    typedef struct packed {
        logic [60:0] rem;
        logic [60:0] root;
    } sqrt_t;

    // Operands that ride alongside the square root chain.
    typedef struct packed {
        logic signed [VEC_W-1:0] yaw_x;
        logic signed [VEC_W-1:0] yaw_y;
        logic signed [VEC_W-1:0] pitch_x;
        logic signed [VEC_W-1:0] pitch_y;
        logic signed [VEC_W-1:0] roll_y;
        logic                    pole;
        logic                    pos;
    } side_t;

    // Pole flag and sign of test, carried along the CORDIC chain.
    typedef struct packed {
        logic pole;
        logic pos;
    } flag_t;

endpackage

`default_nettype wire

/* src/qte_isqrt_cell.sv */
// One cell of the square root chain: resolves one root bit per cycle while en is high.
`default_nettype none

module qte_isqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire qte_pkg::sqrt_t d,
    output qte_pkg::sqrt_t      q
);
    import qte_pkg::*;

    localparam logic [60:0] BIT = 61'(1) << (2 * STEP);

    sqrt_t       q_reg;
    sqrt_t       q_next;
    logic [60:0] trial;

    // Restoring step: subtract the trial value when it fits.
    always_comb begin
        trial  = d.root + BIT;
        q_next = d;
        if (d.rem >= trial) begin
            q_next.rem  = d.rem - trial;
            q_next.root = (d.root >> 1) + BIT;
        end else begin
            q_next.root = d.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* src/qte_cordic_cell.sv */
// One vectoring CORDIC cell: a single micro-rotation per cycle while en is high.
`default_nettype none

module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire qte_pkg::cord_t d,
    output qte_pkg::cord_t      q
);
    import qte_pkg::*;

    // Arctangent of 2^-i scaled 2^30, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] r;
        case (i)
            0:  r = 34'sd843314857;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043837;
            3:  r = 34'sd133525159;
            4:  r = 34'sd67021687;
            5:  r = 34'sd33543516;
            6:  r = 34'sd16775851;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194283;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048576;
            11: r = 34'sd524288;
            12: r = 34'sd262144;
            13: r = 34'sd131072;
            14: r = 34'sd65536;
            15: r = 34'sd32768;
            16: r = 34'sd16384;
            17: r = 34'sd8192;
            18: r = 34'sd4096;
            19: r = 34'sd2048;
            20: r = 34'sd1024;
            21: r = 34'sd512;
            22: r = 34'sd256;
            23: r = 34'sd128;
            24: r = 34'sd64;
            25: r = 34'sd32;
            26: r = 34'sd16;
            27: r = 34'sd8;
            28: r = 34'sd4;
            29: r = 34'sd2;
            30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    localparam logic signed [ANG_W-1:0] ATAN = atan_entry(STAGE);

    cord_t                   q_reg;
    cord_t                   q_next;
    logic signed [VEC_W-1:0] xin;
    logic signed [VEC_W-1:0] yin;
    logic signed [ANG_W-1:0] ain;
    logic signed [VEC_W-1:0] xsh;
    logic signed [VEC_W-1:0] ysh;

    // Rotate toward the x axis according to the sign of y.
    always_comb begin
        xin    = d.xv;
        yin    = d.yv;
        ain    = d.ang;
        xsh    = xin >>> STAGE;
        ysh    = yin >>> STAGE;
        q_next = d;
        if (yin > 0) begin
            q_next.xv  = xin + ysh;
            q_next.yv  = yin - xsh;
            q_next.ang = ain + ATAN;
        end else begin
            q_next.xv  = xin - ysh;
            q_next.yv  = yin + xsh;
            q_next.ang = ain - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* src/quaternion_to_euler.sv */
// Top level of the quaternion to Euler angle converter.
// Throughput: one quaternion per cycle unless the output stalls; every stage is a register cell.
// The depth comes from 31 square root cells and CORDIC_STAGES rotation cells.
// The whole pipeline holds only while a finished result waits and m_ready is low.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
`default_nettype none

module quaternion_to_euler #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_quat_x,
    input  wire logic signed [15:0] s_quat_y,
    input  wire logic signed [15:0] s_quat_z,
    input  wire logic signed [15:0] s_quat_w,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [14:0]      m_pitch_angle,
    output logic signed [15:0]      m_yaw_angle,
    output logic signed [13:0]      m_roll_angle,
    output logic                    m_at_pole
);
    import qte_pkg::*;

    localparam int DEPTH = 3 + ISQRT_STEPS + 1 + CORDIC_STAGES + 1;

    // Quarter-turn pre-rotation for a negative x operand.
    function automatic cord_t cordic_prep(input logic signed [VEC_W-1:0] xv,
                                          input logic signed [VEC_W-1:0] yv);
        cord_t r;
        r.zero = (xv == '0) && (yv == '0);
        r.xv   = xv;
        r.yv   = yv;
        r.ang  = '0;
        if (xv < 0) begin
            if (yv >= 0) begin
                r.xv  = yv;
                r.yv  = -xv;
                r.ang = ANG_PI_HALF;
            end else begin
                r.xv  = -yv;
                r.yv  = xv;
                r.ang = -ANG_PI_HALF;
            end
        end
        return r;
    endfunction

    // Round half up from 2^-30 to 2^-12.
    function automatic logic signed [18:0] round_q12(input logic signed [35:0] v);
        logic signed [36:0] s;
        s = 37'(v) + 37'sd131072;
        return s[36:18];
    endfunction

    function automatic logic signed [18:0] sat(input logic signed [18:0] v,
                                               input logic signed [18:0] lim);
        logic signed [18:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    logic en;
    logic [DEPTH-1:0] vld_reg;

    // Global advance: hold only when the output register is full and not taken.
    assign en      = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // Stage 1: the component products.
    logic signed [31:0] p_xy_reg, p_zw_reg, p_yw_reg, p_xz_reg, p_yy_reg;
    logic signed [31:0] p_zz_reg, p_xw_reg, p_yz_reg, p_xx_reg;
    logic signed [15:0] x1_reg, w1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_xy_reg <= s_quat_x * s_quat_y;
            p_zw_reg <= s_quat_z * s_quat_w;
            p_yw_reg <= s_quat_y * s_quat_w;
            p_xz_reg <= s_quat_x * s_quat_z;
            p_yy_reg <= s_quat_y * s_quat_y;
            p_zz_reg <= s_quat_z * s_quat_z;
            p_xw_reg <= s_quat_x * s_quat_w;
            p_yz_reg <= s_quat_y * s_quat_z;
            p_xx_reg <= s_quat_x * s_quat_x;
            x1_reg   <= s_quat_x;
            w1_reg   <= s_quat_w;
        end
    end

    // Stage 2: test value, pole decision and the atan2 operands.
    logic signed [32:0]      test_next;
    logic signed [33:0]      t_next;
    logic signed [33:0]      tabs_next;
    side_t                   side_next;
    side_t                   side2_reg;
    logic [29:0]             at_reg;
    logic signed [VEC_W-1:0] one_v;

    always_comb begin
        one_v     = 37'sd1073741824;
        test_next = 33'(p_xy_reg) + 33'(p_zw_reg);
        t_next    = 34'(test_next) <<< 1;
        tabs_next = (t_next < 0) ? -t_next : t_next;
        side_next.pole = (test_next > TEST_LIMIT) || (test_next < -TEST_LIMIT);
        side_next.pos  = test_next > 0;
        side_next.roll_y  = 37'(t_next);
        side_next.pitch_y = (37'(p_xw_reg) - 37'(p_yz_reg)) <<< 1;
        side_next.pitch_x = one_v - ((37'(p_xx_reg) + 37'(p_zz_reg)) <<< 1);
        if (side_next.pole) begin
            side_next.yaw_y = 37'(x1_reg) <<< 15;
            side_next.yaw_x = 37'(w1_reg) <<< 15;
        end else begin
            side_next.yaw_y = (37'(p_yw_reg) - 37'(p_xz_reg)) <<< 1;
            side_next.yaw_x = one_v - ((37'(p_yy_reg) + 37'(p_zz_reg)) <<< 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side_next;
            at_reg    <= tabs_next[29:0];
        end
    end

    // Stage 3: square of |2*test| for the roll cosine term.
    logic [59:0] sq_reg;
    side_t       side_reg [0:ISQRT_STEPS];
    sqrt_t       sqrt_d   [0:ISQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg      <= at_reg * at_reg;
            side_reg[0] <= side2_reg;
            for (int k = 0; k < ISQRT_STEPS; k++) begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign sqrt_d[0].rem  = (61'(1) << 60) - 61'(sq_reg);
    assign sqrt_d[0].root = '0;

    // Square root chain, most significant root bit first.
    for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_isqrt
        qte_isqrt_cell #(
            .STEP(ISQRT_STEPS - 1 - k)
        ) u_cell (
            .aclk(aclk),
            .en  (en),
            .d   (sqrt_d[k]),
            .q   (sqrt_d[k+1])
        );
    end

    // Pre-rotation stage for the yaw, pitch and roll vectors.
    cord_t pre_reg  [0:2];
    flag_t flag_reg [0:CORDIC_STAGES];
    side_t side_end;

    assign side_end = side_reg[ISQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_reg[0]    <= cordic_prep(side_end.yaw_x, side_end.yaw_y);
            pre_reg[1]    <= cordic_prep(side_end.pitch_x, side_end.pitch_y);
            pre_reg[2]    <= cordic_prep(37'(sqrt_d[ISQRT_STEPS].root[30:0]),
                                         side_end.roll_y);
            flag_reg[0]   <= '{pole: side_end.pole, pos: side_end.pos};
            for (int s = 0; s < CORDIC_STAGES; s++) begin
                flag_reg[s+1] <= flag_reg[s];
            end
        end
    end

    // Three CORDIC chains side by side.
    cord_t cd [0:CORDIC_STAGES][0:2];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign cd[0][l] = pre_reg[l];
        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
            qte_cordic_cell #(
                .STAGE(s)
            ) u_cell (
                .aclk(aclk),
                .en  (en),
                .d   (cd[s][l]),
                .q   (cd[s+1][l])
            );
        end
    end

    // Output stage: rounding, pole selection and saturation.
    cord_t              yaw_c, pitch_c, roll_c;
    flag_t              flag_end;
    logic signed [35:0] yaw_wide;
    logic signed [18:0] yaw_next, pitch_next, roll_next;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] yaw_reg;
    logic signed [13:0] roll_reg;
    logic               pole_reg;

    always_comb begin
        yaw_c    = cd[CORDIC_STAGES][0];
        pitch_c  = cd[CORDIC_STAGES][1];
        roll_c   = cd[CORDIC_STAGES][2];
        flag_end = flag_reg[CORDIC_STAGES];
        yaw_wide = yaw_c.zero ? 36'sd0 : 36'(yaw_c.ang);
        if (flag_end.pole) begin
            yaw_wide   = flag_end.pos ? (yaw_wide <<< 1) : -(yaw_wide <<< 1);
            yaw_next   = sat(round_q12(yaw_wide), YAW_LIM);
            pitch_next = flag_end.pos ? Q12_HALF_PI : -Q12_HALF_PI;
            roll_next  = '0;
        end else begin
            yaw_next   = sat(round_q12(yaw_wide), YAW_LIM);
            pitch_next = pitch_c.zero ? 19'sd0
                                      : sat(round_q12(36'(pitch_c.ang)), PITCH_LIM);
            roll_next  = roll_c.zero ? 19'sd0
                                     : sat(round_q12(36'(roll_c.ang)), ROLL_LIM);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pitch_reg <= pitch_next[14:0];
            yaw_reg   <= yaw_next[15:0];
            roll_reg  <= roll_next[13:0];
            pole_reg  <= flag_end.pole;
        end
    end

    assign m_pitch_angle = pitch_reg;
    assign m_yaw_angle   = yaw_reg;
    assign m_roll_angle  = roll_reg;
    assign m_at_pole     = pole_reg;

`ifndef SYNTH
    // A pole result never carries a roll angle.
    a_pole_roll: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_at_pole) |-> (m_roll_angle == 14'sd0))
        else $error("pole result with nonzero roll");

    // Saturation keeps results inside their documented ranges.
    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_pitch_angle <= 15'sd12868) && (m_pitch_angle >= -15'sd12868)
                  && (m_yaw_angle <= 16'sd25736) && (m_yaw_angle >= -16'sd25736)))
        else $error("result outside range");

    // While the output stalls, no item moves inside the pipeline.
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

/* dv/quaternion_to_euler_tb.sv */
// Self-checking testbench for the quaternion to Euler angle converter.
`timescale 1ns / 100ps
`default_nettype none

module quaternion_to_euler_tb;

    localparam int STAGES = 16;

    // Angle table, atan(2^-i) scaled 2^30.
    localparam longint ATAN_LUT [32] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128,
        64, 32, 16, 8, 4, 2, 1, 0};
    localparam longint QUARTER_TURN = 64'sd1686629713;
    localparam longint UNIT_ANG = 64'sd1073741824;
    localparam longint POLE_LIMIT = 64'sd535822336;

    typedef struct {
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic signed [13:0] roll;
        logic               pole;
    } euler_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_quat_x = '0, s_quat_y = '0, s_quat_z = '0, s_quat_w = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [14:0] m_pitch_angle;
    logic signed [15:0] m_yaw_angle;
    logic signed [13:0] m_roll_angle;
    logic m_at_pole;

    euler_t angles_due[$];
    int     mismatches = 0;
    bit     calm = 1'b0;

    quaternion_to_euler #(.CORDIC_STAGES(STAGES)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_x(s_quat_x), .s_quat_y(s_quat_y),
        .s_quat_z(s_quat_z), .s_quat_w(s_quat_w),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pitch_angle(m_pitch_angle), .m_yaw_angle(m_yaw_angle),
        .m_roll_angle(m_roll_angle), .m_at_pole(m_at_pole)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    // Arithmetic shift right that rounds toward minus infinity.
    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    // Vectoring CORDIC angle of (xv, yv), scaled 2^-30 rad.
    function automatic longint vec_angle(longint yv, longint xv);
        longint ang, tmp, nx, ny;
        ang = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            tmp = xv;
            if (yv >= 0) begin
                xv = yv; yv = -tmp; ang = QUARTER_TURN;
            end else begin
                xv = -yv; yv = tmp; ang = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < STAGES && i < 32; i++) begin
            if (yv > 0) begin
                nx = xv + asr(yv, i); ny = yv - asr(xv, i); ang += ATAN_LUT[i];
            end else begin
                nx = xv - asr(yv, i); ny = yv + asr(xv, i); ang -= ATAN_LUT[i];
            end
            xv = nx; yv = ny;
        end
        return ang;
    endfunction

    function automatic longint rad_q12(longint ang, longint lim);
        longint r;
        r = asr(ang + (64'sd1 << 17), 18);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b; res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Expected Euler angles of one quaternion.
    function automatic euler_t euler_of(logic signed [15:0] qx, logic signed [15:0] qy,
                                        logic signed [15:0] qz, logic signed [15:0] qw);
        euler_t e;
        longint x, y, z, w, tst, sgn, t, a;
        longint unsigned at, c;
        x = qx; y = qy; z = qz; w = qw;
        tst = x * y + z * w;
        if (tst > POLE_LIMIT || tst < -POLE_LIMIT) begin
            sgn = tst > 0 ? 1 : -1;
            a = vec_angle(x * 32768, w * 32768);
            e.yaw = 16'(rad_q12(2 * a * sgn, 25736));
            e.pitch = 15'(sgn * 6434);
            e.roll = '0;
            e.pole = 1'b1;
        end else begin
            t = 2 * tst;
            at = unsigned'(t < 0 ? -t : t);
            c = root_floor((64'd1 << 60) - at * at);
            e.yaw = 16'(rad_q12(vec_angle(2 * (y * w - x * z),
                                 UNIT_ANG - 2 * (y * y + z * z)), 25736));
            e.pitch = 15'(rad_q12(vec_angle(2 * (x * w - y * z),
                                   UNIT_ANG - 2 * (x * x + z * z)), 12868));
            e.roll = 14'(rad_q12(vec_angle(t, longint'(c)), 6434));
            e.pole = 1'b0;
        end
        return e;
    endfunction

    // Sends one quaternion and queues its expected angles on transfer.
    task automatic send_quat(logic [15:0] qx, logic [15:0] qy,
                             logic [15:0] qz, logic [15:0] qw);
        while (!calm && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_quat_x <= qx; s_quat_y <= qy; s_quat_z <= qz; s_quat_w <= qw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        angles_due.push_back(euler_of(qx, qy, qz, qw));
    endtask

    task automatic test_extremes();
        logic [15:0] ext[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        for (int i = 0; i < 20; i++)
            send_quat(ext[i % 5], ext[(i / 5) % 5], ext[(i * 3) % 5], ext[(i * 7 + 1) % 5]);
    endtask

    task automatic test_special();
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000); // all zero
        send_quat(16'h5A82, 16'h5A82, 16'h0000, 16'h0000); // positive pole
        send_quat(16'h5A82, 16'hA57E, 16'h0000, 16'h0000); // negative pole
        send_quat(16'h0000, 16'h0000, 16'h5A82, 16'h5A82); // pole via zw
        send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000); // near pole threshold
    endtask

    // Random quaternions: half with components within +-16000, some raw noise, some near poles.
    task automatic test_random(int count);
        int kind;
        logic signed [15:0] a, b;
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 2 && n < count / 2 + 150);
            kind = $urandom_range(9);
            if (kind < 3) begin
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end else if (kind < 5) begin
                a = 16'($urandom_range(23000, 23300));
                b = 16'($urandom_range(23000, 23300));
                if ($urandom_range(1)) b = -b;
                send_quat(a, b, 16'($urandom_range(0, 400) - 200),
                          16'($urandom_range(0, 400) - 200));
            end else begin
                send_quat(16'($urandom_range(0, 32000) - 16000),
                          16'($urandom_range(0, 32000) - 16000),
                          16'($urandom_range(0, 32000) - 16000),
                          16'($urandom_range(0, 32000) - 16000));
            end
        end
        calm = 1'b0;
    endtask

    // Result sink: random stalls, then checks each transfer field by field.
    initial begin
        euler_t e;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (angles_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result transfer");
                end else begin
                    e = angles_due.pop_front();
                    if (e.pitch !== m_pitch_angle || e.yaw !== m_yaw_angle ||
                        e.roll !== m_roll_angle || e.pole !== m_at_pole) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch exp p=%0d y=%0d r=%0d pole=%0b",
                                     e.pitch, e.yaw, e.roll, e.pole);
                            $display("         got p=%0d y=%0d r=%0d pole=%0b",
                                     m_pitch_angle, m_yaw_angle, m_roll_angle,
                                     m_at_pole);
                        end
                    end
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 26);
        end
    end

    initial begin
        int wait_cycles;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_special();
        test_random(1250);
        s_valid <= 1'b0;
        wait_cycles = 0;
        while (angles_due.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && angles_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
